@@ hw/rtl/color_palette_lut_interp_defines.svh @@
// ----------------------------------------------------------------------------
// color_palette_lut_interp_defines.svh
// assertion macros shared by the palette lut checker
// ----------------------------------------------------------------------------
`ifndef COLOR_PALETTE_LUT_INTERP_DEFINES_SVH
`define COLOR_PALETTE_LUT_INTERP_DEFINES_SVH

// same-cycle implication under reset
`define CPLI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("palette lut: implication check failed");

// next-cycle implication under reset
`define CPLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("palette lut: next-cycle check failed");

`endif

@@ hw/rtl/cpli_pkg.sv @@
// ----------------------------------------------------------------------------
// cpli_pkg
// types, widths and helpers for the color palette lut with interpolation
// ----------------------------------------------------------------------------
package cpli_pkg;

	localparam int DEPTH     = 256;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CH_W      = 8;
	localparam int COLOR_W   = 3 * CH_W;
	localparam int USED_W    = 9;
	localparam int POS_W     = 17;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = POS_W + USED_W;
	localparam int ENT_W     = PROD_W - FRAC_BITS;
	localparam int BL_W      = (CH_W + 1) + (FRAC_BITS + 1);
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 24;
	localparam int MIN_USED  = 2;

	localparam logic [POS_W-1:0]  ONE_FIX  = POS_W'(1) << FRAC_BITS;
	localparam logic [USED_W-1:0] USED_MIN = USED_W'(MIN_USED);
	localparam logic [USED_W-1:0] USED_MAX = USED_W'(DEPTH);

	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_NEAREST = 2'd2,
		FUNC_LINEAR  = 2'd3
	} func_t;

	// gray ramp entry value, i*255/(DEPTH-1) reduces to i for 256 entries
	function automatic logic [COLOR_W-1:0] gray_of(input logic [ADDR_W-1:0] addr);
		logic [CH_W-1:0] g;
		g = CH_W'(addr);
		return {g, g, g};
	endfunction

endpackage

@@ hw/rtl/color_palette_lut_interp.sv @@
// ----------------------------------------------------------------------------
// color_palette_lut_interp
// registers from an accepted input word to its result word: stage 1, stage 2, output
// throughput: one word per cycle, one palette write port and two read ports
// a full output register that is not taken stalls the whole pipeline
// reset: entries_used is 256, palette reads as a gray ramp via per-entry
// valid bits cleared at once, no clearing pass
// ----------------------------------------------------------------------------
module color_palette_lut_interp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cpli_pkg::USED_W-1:0]    cfg_wdata,   // entries_used
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// index, red_in, green_in, blue_in, position, zero pad
	input  logic [cpli_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [1:0]                     s_tuser,     // func
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// red_out, green_out, blue_out
	output logic [cpli_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [0:0]                     m_tuser      // valid_res
);
	import cpli_pkg::*;

	logic                  adv;
	logic [USED_W-1:0]     used_q;

	// stage 1: captured word
	logic                  v_s1;
	func_t                 func_s1;
	logic [ADDR_W-1:0]     idx_s1;
	logic [COLOR_W-1:0]    wcol_s1;
	logic [POS_W-1:0]      t_s1;

	// stage 1 decode
	logic [USED_W-1:0]     last;
	logic [USED_W-1:0]     mul_op;
	logic [PROD_W-1:0]     prod;
	logic [ENT_W-1:0]      ent;
	logic [USED_W-1:0]     near_e;
	logic [USED_W-1:0]     lo_e;
	logic [USED_W-1:0]     hi_e;
	logic                  in_rng;
	logic [ADDR_W-1:0]     addr_a;
	logic [ADDR_W-1:0]     addr_b;
	logic [FRAC_BITS-1:0]  wgt;
	logic                  zero;
	logic                  vres;
	logic                  do_wr;

	// palette memory
	logic [COLOR_W-1:0]    mem [DEPTH];
	logic [DEPTH-1:0]      pvld_q;

	// stage 2
	logic                  v_s2;
	logic [COLOR_W-1:0]    rd_a_s2;
	logic [COLOR_W-1:0]    rd_b_s2;
	logic                  pv_a_s2;
	logic                  pv_b_s2;
	logic [ADDR_W-1:0]     addr_a_s2;
	logic [ADDR_W-1:0]     addr_b_s2;
	logic [FRAC_BITS-1:0]  wgt_s2;
	logic                  zero_s2;
	logic                  vres_s2;

	logic [COLOR_W-1:0]    col_a;
	logic [COLOR_W-1:0]    col_b;
	logic [CH_W-1:0]       ca [3];
	logic [CH_W-1:0]       cb [3];
	logic signed [CH_W:0]  diff [3];
	logic signed [BL_W-1:0] bprod [3];
	logic signed [CH_W+1:0] bsum [3];
	logic [CH_W-1:0]       res [3];

	// output register
	logic                  o_valid_q;
	logic [M_TDATA_W-1:0]  o_data_q;
	logic                  o_vres_q;

	assign adv      = !o_valid_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = o_valid_q;
	assign m_tdata  = o_data_q;
	assign m_tuser  = o_vres_q;

	// config register, stored already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= USED_MAX;
		end else if (cfg_we) begin
			if (cfg_wdata < USED_MIN) begin
				used_q <= USED_MIN;
			end else if (cfg_wdata > USED_MAX) begin
				used_q <= USED_MAX;
			end else begin
				used_q <= cfg_wdata;
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			o_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1      <= s_tvalid;
			v_s2      <= v_s1;
			o_valid_q <= v_s2;
		end
	end

	// stage 1 capture, position saturates at 1.0
	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= func_t'(s_tuser);
			idx_s1  <= s_tdata[7:0];
			wcol_s1 <= {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
			t_s1    <= (s_tdata[48:32] > ONE_FIX) ? ONE_FIX : s_tdata[48:32];
		end
	end

	// stage 1 address generation
	always_comb begin
		last   = used_q - USED_W'(1);
		mul_op = (func_s1 == FUNC_LINEAR) ? last : used_q;
		prod   = PROD_W'(t_s1) * PROD_W'(mul_op);
		ent    = prod[PROD_W-1:FRAC_BITS];
		near_e = (ent >= ENT_W'(used_q)) ? last : ent[USED_W-1:0];
		lo_e   = (ent > ENT_W'(last)) ? last : ent[USED_W-1:0];
		hi_e   = (lo_e + USED_W'(1) > last) ? last : lo_e + USED_W'(1);
		in_rng = USED_W'(idx_s1) < used_q;
		addr_a = idx_s1;
		addr_b = idx_s1;
		wgt    = '0;
		zero   = 1'b0;
		vres   = 1'b1;
		do_wr  = 1'b0;
		case (func_s1)
			FUNC_WRITE: begin
				zero  = 1'b1;
				vres  = in_rng;
				do_wr = v_s1 && in_rng;
			end
			FUNC_READ: begin
				zero = !in_rng;
				vres = in_rng;
			end
			FUNC_NEAREST: begin
				addr_a = near_e[ADDR_W-1:0];
				addr_b = near_e[ADDR_W-1:0];
			end
			FUNC_LINEAR: begin
				addr_a = lo_e[ADDR_W-1:0];
				addr_b = hi_e[ADDR_W-1:0];
				wgt    = prod[FRAC_BITS-1:0];
			end
			default: begin
				zero = 1'b1;
			end
		endcase
	end

	// palette storage, one write and two registered reads
	always_ff @(posedge clk) begin
		if (adv) begin
			if (do_wr) begin
				mem[idx_s1] <= wcol_s1;
			end
			rd_a_s2 <= mem[addr_a];
			rd_b_s2 <= mem[addr_b];
		end
	end

	// per-entry written marks, unwritten entries read as the gray ramp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q <= '0;
		end else if (adv && do_wr) begin
			pvld_q[idx_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pv_a_s2   <= pvld_q[addr_a];
			pv_b_s2   <= pvld_q[addr_b];
			addr_a_s2 <= addr_a;
			addr_b_s2 <= addr_b;
			wgt_s2    <= wgt;
			zero_s2   <= zero;
			vres_s2   <= vres;
		end
	end

	// stage 2 blend per channel: a + ((b - a) * w) >>> frac
	always_comb begin
		col_a = pv_a_s2 ? rd_a_s2 : gray_of(addr_a_s2);
		col_b = pv_b_s2 ? rd_b_s2 : gray_of(addr_b_s2);
		ca[0] = col_a[3*CH_W-1:2*CH_W];
		ca[1] = col_a[2*CH_W-1:CH_W];
		ca[2] = col_a[CH_W-1:0];
		cb[0] = col_b[3*CH_W-1:2*CH_W];
		cb[1] = col_b[2*CH_W-1:CH_W];
		cb[2] = col_b[CH_W-1:0];
		for (int c = 0; c < 3; c++) begin
			diff[c]  = $signed({1'b0, cb[c]}) - $signed({1'b0, ca[c]});
			bprod[c] = BL_W'(diff[c]) * BL_W'($signed({1'b0, wgt_s2}));
			bsum[c]  = $signed({2'b00, ca[c]}) + bprod[c][BL_W-1:FRAC_BITS];
			res[c]   = zero_s2 ? '0 : bsum[c][CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			o_data_q <= {res[2], res[1], res[0]};
			o_vres_q <= vres_s2;
		end
	end

endmodule

@@ hw/rtl/cpli_checker.sv @@
// ----------------------------------------------------------------------------
// cpli_checker
// port-level checks for the color palette lut, bound to the top level
// ----------------------------------------------------------------------------
`include "color_palette_lut_interp_defines.svh"

module cpli_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [cpli_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [0:0]                     m_tuser
);
	import cpli_pkg::*;

	logic out_stall;

	assign out_stall = m_tvalid && !m_tready;

	// a stalled result word holds
	`CPLI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// an empty output register never blocks input
	`CPLI_ASSERT_IMPL(a_ready_empty, clk, arst_n, !m_tvalid, s_tready)

	// a taken result frees the pipeline in the same cycle
	`CPLI_ASSERT_IMPL(a_ready_take, clk, arst_n, m_tready, s_tready)

	// a rejected write or read carries a black color
	`CPLI_ASSERT_IMPL(a_invalid_black, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == '0)

endmodule

bind color_palette_lut_interp cpli_checker u_cpli_checker (.*);
